// ===== hw/rtl/ecl_pkg.sv =====
// Shared types and constants for the escaped command channel loader.
package ecl_pkg;

  localparam int unsigned ChannelCount = 512;
  localparam int unsigned ChanW        = $clog2(ChannelCount);
  localparam int unsigned IdxW         = 9;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned InDataW      = 8;
  localparam int unsigned OutDataW     = 24;

  // Register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] CfgEscape   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLoadOp   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgClearOp  = 2'd2;

  localparam logic [ByteW-1:0] EscapeReset  = 8'd125;
  localparam logic [ByteW-1:0] LoadOpReset  = 8'd102;
  localparam logic [ByteW-1:0] ClearOpReset = 8'd101;

  typedef enum logic [1:0] {
    ModeIdle   = 2'd0,
    ModeLoad   = 2'd1,
    ModeIgnore = 2'd2
  } mode_e;

  typedef struct packed {
    logic [ByteW-1:0] escape_byte;
    logic [ByteW-1:0] load_opcode;
    logic [ByteW-1:0] clear_errors_opcode;
  } cfg_t;

  typedef struct packed {
    logic [IdxW-1:0]  channel_index;
    logic [ByteW-1:0] channel_value;
    logic             store_strobe;
    logic             final_channel;
  } result_t;

endpackage

// ===== hw/rtl/ecl_cfg.sv =====
// Configuration register file: escape byte and the two opcodes.
module ecl_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ecl_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ecl_pkg::ByteW-1:0]   cfg_data_i,
  output ecl_pkg::cfg_t               cfg_o
);
  import ecl_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgEscape:  cfg_d.escape_byte         = cfg_data_i;
        CfgLoadOp:  cfg_d.load_opcode         = cfg_data_i;
        CfgClearOp: cfg_d.clear_errors_opcode = cfg_data_i;
        default:    cfg_d = cfg_q; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.escape_byte         <= EscapeReset;
      cfg_q.load_opcode         <= LoadOpReset;
      cfg_q.clear_errors_opcode <= ClearOpReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/ecl_cmd.sv =====
// Input register, escape/opcode decoder and channel counter.
module ecl_cmd (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ecl_pkg::cfg_t             cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ecl_pkg::ByteW-1:0] in_byte_i,
  input  logic                      in_writable_i,
  input  logic                      advance_i,
  output logic                      res_valid_o,
  output ecl_pkg::result_t          res_o
);
  import ecl_pkg::*;

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_wr_q;
  logic             esc_q, esc_d;
  mode_e            mode_q, mode_d;
  logic [ChanW-1:0] chan_q, chan_d;
  logic             proc;
  logic             emit;
  logic             last;
  logic [ChanW+IdxW-1:0] chan_ext;

  assign proc       = in_valid_q && advance_i;
  assign in_ready_o = !in_valid_q || advance_i;
  assign last       = (chan_q == ChanW'(ChannelCount - 1));
  assign chan_ext   = {{IdxW{1'b0}}, chan_q};

  always_comb begin
    esc_d  = esc_q;
    mode_d = mode_q;
    chan_d = chan_q;
    emit   = 1'b0;
    if (proc) begin
      if (!esc_q && in_byte_q == cfg_i.escape_byte) begin
        esc_d = 1'b1;
      end else if (esc_q && in_byte_q != cfg_i.escape_byte) begin
        // opcode byte
        esc_d = 1'b0;
        if (in_byte_q == cfg_i.load_opcode) begin
          mode_d = ModeLoad;
          chan_d = '0;
        end else if (in_byte_q != cfg_i.clear_errors_opcode) begin
          mode_d = ModeIgnore;
        end
      end else begin
        // data byte, including a doubled escape
        esc_d = 1'b0;
        if (mode_q != ModeLoad) begin
          mode_d = ModeIdle;
        end else begin
          emit = 1'b1;
          if (last) begin
            chan_d = '0;
            mode_d = ModeIdle;
          end else begin
            chan_d = chan_q + ChanW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      esc_q      <= 1'b0;
      mode_q     <= ModeIdle;
      chan_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      esc_q  <= esc_d;
      mode_q <= mode_d;
      chan_q <= chan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
      in_wr_q   <= in_writable_i;
    end
  end

  assign res_valid_o         = emit;
  assign res_o.channel_index = chan_ext[IdxW-1:0];
  assign res_o.channel_value = in_byte_q;
  assign res_o.store_strobe  = in_wr_q;
  assign res_o.final_channel = last;

  a_final_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last) |=> (chan_q == '0 && mode_q == ModeIdle))
    else $error("channel counter did not wrap after the final channel");

  a_escape_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && !esc_q && in_byte_q == cfg_i.escape_byte) |=> esc_q)
    else $error("lone escape did not arm opcode mode");

  a_emit_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (mode_q == ModeLoad && in_valid_q && advance_i))
    else $error("result produced outside load mode");

  a_no_advance_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !proc |=> ($stable(chan_q) && $stable(esc_q)))
    else $error("decoder state moved without a processed byte");

endmodule

// ===== hw/rtl/ecl_out.sv =====
// Result register driving the master-side stream.
module ecl_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  input  ecl_pkg::result_t res_i,
  output logic             advance_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ecl_pkg::result_t out_o
);
  import ecl_pkg::*;

  logic    out_valid_q;
  result_t out_q;

  // Hold the result while the receiver stalls
  assign advance_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_o) begin
      out_valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      out_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== hw/rtl/escaped_command_channel_loader.sv =====
// Escaped command channel loader: turns a received byte stream into channel writes.
//
// Slave stream: one received byte per transfer, s_axis_tdata = rx_byte and
// s_axis_tuser = table_writable. A lone escape byte arms opcode mode and the
// next byte is decoded as an opcode; a doubled escape passes on as data. The
// load opcode starts loading at channel 0, the clear-errors opcode keeps the
// mode, any other opcode selects ignore mode. In load mode each data byte
// gives one master transfer: channel index, value, store strobe (tuser) and
// tlast on the final channel, after which the block returns to idle.
// Configuration channel: register 0 escape byte, 1 load opcode, 2 clear-errors
// opcode; always ready. The user must write it only while the stream is quiet;
// the block itself does not enforce this. A byte lands in the input register
// at its transfer; the decode is combinational and the result register loads
// its result, waiting while the master side stalls. Throughput: one byte per
// cycle while the master side does not stall, set by the single decode stage
// between the two registers. Reset clears the decoder to idle, channel 0 and the
// default register values. When the master side stalls, the held result blocks
// the decode stage and s_axis_tready drops once the input register is full as well.
module escaped_command_channel_loader (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [ecl_pkg::InDataW-1:0]  s_axis_tdata,  // [7:0] rx_byte
  input  logic [0:0]                   s_axis_tuser,  // [0] table_writable
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [ecl_pkg::OutDataW-1:0] m_axis_tdata,  // [8:0] channel_index,
                                                      // [16:9] channel_value
  output logic [0:0]                   m_axis_tuser,  // [0] store_strobe
  output logic                         m_axis_tlast,  // final_channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ecl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ecl_pkg::ByteW-1:0]    cfg_data_i
);
  import ecl_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t out;
  logic    res_valid;
  logic    advance;

  ecl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ecl_cmd u_cmd (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_byte_i     (s_axis_tdata[ByteW-1:0]),
    .in_writable_i (s_axis_tuser[0]),
    .advance_i     (advance),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  ecl_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out)
  );

  assign m_axis_tdata = {{(OutDataW - IdxW - ByteW){1'b0}},
                         out.channel_value, out.channel_index};
  assign m_axis_tuser = out.store_strobe;
  assign m_axis_tlast = out.final_channel;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the escaped command channel loader.
`timescale 1ns / 1ps

module testbench;
  import ecl_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int unsigned        SettleCycles = 8;

  typedef struct {
    logic [ByteW-1:0] rx_byte;
    logic             writable;
  } rx_item_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;  // [7:0] rx_byte
  logic [0:0]          s_axis_tuser;  // [0] table_writable
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;  // [8:0] channel_index, [16:9] channel_value
  logic [0:0]          m_axis_tuser;  // [0] store_strobe
  logic                m_axis_tlast;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [ByteW-1:0]    cfg_data_i;

  escaped_command_channel_loader u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Decoder copy: configuration and state
  logic [ByteW-1:0] esc_byte;
  logic [ByteW-1:0] load_op;
  logic [ByteW-1:0] clear_op;
  logic             esc_armed;
  mode_e            cur_mode;
  int unsigned      chan_ptr;

  rx_item_t pending_bytes[$];
  result_t  expected_writes[$];

  logic in_accepted;
  int   burst_left;
  int   gap_left;
  int   stall_style;
  int   style_left;
  int   stall_cycle;
  int   mismatches;
  int   bytes_queued;
  int   writes_checked;
  int   stores_seen;
  int   wraps_seen;
  int   settings_used;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Work out the channel write, if any, that one received byte causes.
  function automatic bit predict_write(input logic [ByteW-1:0] rx, input logic wr,
                                       output result_t res);
    res = '0;
    if (!esc_armed && rx == esc_byte) begin
      esc_armed = 1'b1;
      return 1'b0;
    end
    if (esc_armed && rx != esc_byte) begin
      esc_armed = 1'b0;
      if (rx == load_op) begin
        cur_mode = ModeLoad;
        chan_ptr = 0;
      end else if (rx != clear_op) begin
        cur_mode = ModeIgnore;
      end
      return 1'b0;
    end
    // plain data, or the second half of a doubled escape
    esc_armed = 1'b0;
    if (cur_mode != ModeLoad) begin
      cur_mode = ModeIdle;
      return 1'b0;
    end
    res.channel_index = chan_ptr[IdxW-1:0];
    res.channel_value = rx;
    res.store_strobe  = wr;
    res.final_channel = (chan_ptr >= ChannelCount - 1);
    if (res.final_channel) begin
      chan_ptr = 0;
      cur_mode = ModeIdle;
    end else begin
      chan_ptr = chan_ptr + 1;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin : monitor
    result_t got;
    result_t exp_w;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.channel_index = m_axis_tdata[IdxW-1:0];
        got.channel_value = m_axis_tdata[IdxW+ByteW-1:IdxW];
        got.store_strobe  = m_axis_tuser[0];
        got.final_channel = m_axis_tlast;
        if (expected_writes.size() == 0) begin
          $error("unexpected channel write: index %0d value %0d", got.channel_index,
                 got.channel_value);
          mismatches++;
        end else begin
          exp_w = expected_writes.pop_front();
          if (got.channel_index !== exp_w.channel_index) begin
            $error("channel_index: expected %0d, got %0d", exp_w.channel_index,
                   got.channel_index);
            mismatches++;
          end
          if (got.channel_value !== exp_w.channel_value) begin
            $error("channel_value: expected %0d, got %0d", exp_w.channel_value,
                   got.channel_value);
            mismatches++;
          end
          if (got.store_strobe !== exp_w.store_strobe) begin
            $error("store_strobe: expected %0b, got %0b", exp_w.store_strobe,
                   got.store_strobe);
            mismatches++;
          end
          if (got.final_channel !== exp_w.final_channel) begin
            $error("final_channel: expected %0b, got %0b", exp_w.final_channel,
                   got.final_channel);
            mismatches++;
          end
          writes_checked++;
          if (exp_w.store_strobe) stores_seen++;
          if (exp_w.final_channel) wraps_seen++;
        end
      end
      in_accepted = s_axis_tvalid && s_axis_tready;
      if (in_accepted && predict_write(s_axis_tdata[ByteW-1:0], s_axis_tuser[0], exp_w))
        expected_writes.push_back(exp_w);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgEscape:  esc_byte = cfg_data_i;
          CfgLoadOp:  load_op  = cfg_data_i;
          CfgClearOp: clear_op = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always @(negedge clk_i) begin : driver
    rx_item_t it;
    if (!s_axis_tvalid || in_accepted) begin
      if (gap_left > 0 || pending_bytes.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_axis_tvalid <= 1'b0;
      end else begin
        it = pending_bytes.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.rx_byte;
        s_axis_tuser  <= it.writable;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    // receiver: switch at random between stall styles
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 3);
      style_left  = $urandom_range(20, 300);
    end else begin
      style_left--;
    end
    stall_cycle++;
    case (stall_style)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= (stall_cycle % 4 == 0);
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic push_rx(input logic [ByteW-1:0] b);
    rx_item_t it;
    it.rx_byte  = b;
    it.writable = 1'($urandom_range(0, 1));
    pending_bytes.push_back(it);
    bytes_queued++;
  endtask

  // Data byte; an escape value goes out doubled so that it stays data.
  task automatic push_data();
    logic [ByteW-1:0] b;
    b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 15) == 0) b = esc_byte;
    if (b == esc_byte) push_rx(esc_byte);
    push_rx(b);
  endtask

  task automatic push_other_opcode();
    logic [ByteW-1:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == esc_byte || b == load_op || b == clear_op) b = 8'($urandom_range(0, 255));
    push_rx(esc_byte);
    push_rx(b);
  endtask

  task automatic queue_random_traffic(input int budget);
    int start;
    int n;
    int pick;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        push_rx(esc_byte);
        push_rx(load_op);
        n = $urandom_range(1, 30);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 19) == 0) begin
            push_rx(esc_byte);
            push_rx(clear_op);
          end else begin
            push_data();
          end
        end
      end else if (pick < 80) begin
        push_other_opcode();
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) push_data();
      end else if (pick < 90) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) push_rx(8'($urandom_range(0, 255)));
      end else begin
        // lone escape followed by anything at all
        push_rx(esc_byte);
        push_rx(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Load the whole table and run a few bytes past the wrap.
  task automatic queue_full_load();
    push_rx(esc_byte);
    push_rx(load_op);
    for (int i = 0; i < ChannelCount + 3; i++) begin
      if ($urandom_range(0, 49) == 0) begin
        push_rx(esc_byte);
        push_rx(clear_op);
      end
      push_data();
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold until every byte is taken and every write has arrived, then settle.
  task automatic drain_stream();
    @(negedge clk_i);
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_writes.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    logic [ByteW-1:0] e;
    logic [ByteW-1:0] l;
    logic [ByteW-1:0] c;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CfgEscape;
    cfg_data_i    = '0;
    esc_byte      = EscapeReset;
    load_op       = LoadOpReset;
    clear_op      = ClearOpReset;
    esc_armed     = 1'b0;
    cur_mode      = ModeIdle;
    chan_ptr      = 0;
    in_accepted   = 1'b0;
    burst_left    = 1;
    gap_left      = 0;
    stall_style   = 0;
    style_left    = 0;
    stall_cycle   = 0;
    mismatches    = 0;
    bytes_queued  = 0;
    writes_checked = 0;
    stores_seen   = 0;
    wraps_seen    = 0;
    settings_used = 1;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed bytes with the reset register values
    push_rx(8'h00);                      // data while idle
    push_rx(esc_byte); push_rx(load_op);
    push_rx(8'h00);
    push_rx(8'hFF);
    push_rx(esc_byte); push_rx(esc_byte); // doubled escape stored as data
    push_rx(esc_byte); push_rx(clear_op); // keep load mode
    push_rx(8'hAA);
    push_rx(esc_byte); push_rx(load_op);  // restart at channel 0
    push_rx(8'h55);
    push_rx(esc_byte); push_rx(8'h00);    // unknown opcode: ignore
    push_rx(8'h12);
    push_rx(esc_byte); push_rx(esc_byte); // literal while idle
    push_rx(8'h7E);
    push_rx(esc_byte); push_rx(clear_op); // clear while idle
    push_rx(8'h33);
    queue_random_traffic(150);
    drain_stream();

    // Low escape, top load opcode, full table load
    write_reg(CfgEscape, 8'h00);
    write_reg(CfgLoadOp, 8'hFF);
    write_reg(CfgClearOp, 8'h01);
    settings_used++;
    queue_full_load();
    queue_random_traffic(120);
    drain_stream();

    // Top escape, load and clear opcodes equal
    write_reg(CfgEscape, 8'hFF);
    write_reg(CfgLoadOp, 8'h00);
    write_reg(CfgClearOp, 8'h00);
    write_reg(CfgUnused, 8'($urandom_range(0, 255)));
    settings_used++;
    queue_random_traffic(300);
    drain_stream();

    // Random distinct codes
    e = 8'($urandom_range(0, 255));
    l = 8'($urandom_range(0, 255));
    while (l == e) l = 8'($urandom_range(0, 255));
    c = 8'($urandom_range(0, 255));
    while (c == e || c == l) c = 8'($urandom_range(0, 255));
    write_reg(CfgEscape, e);
    write_reg(CfgLoadOp, l);
    write_reg(CfgClearOp, c);
    settings_used++;
    queue_full_load();
    queue_random_traffic(100);
    drain_stream();

    $display("Run covered %0d received bytes over %0d register settings.", bytes_queued,
             settings_used);
    $display("Checked %0d channel writes (%0d stored), %0d full table loads.",
             writes_checked, stores_seen, wraps_seen);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d writes outstanding", expected_writes.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ecl_pkg.sv
hw/rtl/ecl_cfg.sv
hw/rtl/ecl_cmd.sv
hw/rtl/ecl_out.sv
hw/rtl/escaped_command_channel_loader.sv
tb/sv/testbench.sv
